// ===== src/range_minimum_segment_tree_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef RANGE_MINIMUM_SEGMENT_TREE_DEFINES_SVH
`define RANGE_MINIMUM_SEGMENT_TREE_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define RMST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define RMST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rmst_pkg.sv =====
// ----------------------------------------------------------------------------
// rmst_pkg
// Types, constants and helpers of the range-minimum segment tree.
// ----------------------------------------------------------------------------
`default_nettype none

package rmst_pkg;

    localparam int LEAVES_DEFAULT = 1024;
    localparam int IDX_W          = 10;
    localparam int VAL_W          = 32;

    localparam logic signed [VAL_W-1:0] NEUTRAL = 32'sh7FFF_FFFF;

    typedef enum logic [0:0] {
        OP_UPDATE = 1'b0,
        OP_QUERY  = 1'b1
    } t_op;

    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] value;
    } t_result;

    function automatic logic signed [VAL_W-1:0] min_s(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ===== src/rmst_if.sv =====
// ----------------------------------------------------------------------------
// rmst_in_if / rmst_out_if
// Valid/ready channels carrying request words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmst_in_if;
    logic                                  valid;
    logic                                  ready;
    rmst_pkg::t_op                         operation;
    logic [rmst_pkg::IDX_W-1:0]            first_index;
    logic [rmst_pkg::IDX_W-1:0]            last_index;
    logic signed [rmst_pkg::VAL_W-1:0]     new_value;

    modport source (output valid, operation, first_index, last_index, new_value,
                    input ready);
    modport sink   (input valid, operation, first_index, last_index, new_value,
                    output ready);
endinterface

interface rmst_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rmst_pkg::VAL_W-1:0]     range_minimum;

    modport source (output valid, range_minimum, input ready);
    modport sink   (input valid, range_minimum, output ready);
endinterface

`default_nettype wire

// ===== src/range_minimum_segment_tree.sv =====
// ----------------------------------------------------------------------------
// range_minimum_segment_tree
// Minimum segment tree over LEAVES signed 32-bit positions, point update and
// inclusive range-minimum query.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries request words: operation (update or query), first_index,
//   last_index and new_value. o_result carries one range_minimum word for each
//   query; updates give no word. An empty range returns 2147483647.
//   The block works on one request at a time; i_item.ready is high while it
//   is idle. An update writes the leaf and then walks the ancestors one level
//   a cycle. A query walks the levels bottom-up with up to three steps a
//   level, at most two of them node memory reads; the word then enters the
//   output register once it has room. The node memory has a single read
//   port. After reset a clearing pass writes 2147483647 to all 2*LEAVES
//   nodes with i_item.ready low.
//   When the receiver stalls, the output register holds its word and the
//   block still takes requests; a second query finishing meanwhile waits in
//   the tree until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module range_minimum_segment_tree #(
    parameter int LEAVES = rmst_pkg::LEAVES_DEFAULT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rmst_in_if.sink    i_item,
    rmst_out_if.source o_result
);

    rmst_pkg::t_result w_push;
    logic              w_free;

    rmst_tree #(
        .LEAVES (LEAVES)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_free  (w_free),
        .o_push  (w_push)
    );

    rmst_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_free   (w_free),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ===== src/rmst_tree.sv =====
// ----------------------------------------------------------------------------
// rmst_tree
// Node memory with its clearing pass, update walk and query walk.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_tree #(
    parameter int LEAVES = rmst_pkg::LEAVES_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rmst_in_if.sink          i_item,
    input  wire logic        i_free,
    output rmst_pkg::t_result o_push
);

    localparam int LVL   = $clog2(LEAVES);
    localparam int AW    = LVL + 1;
    localparam int DEPTH = 2 * LEAVES;
    localparam int CW    = ((AW > rmst_pkg::IDX_W) ? AW : rmst_pkg::IDX_W) + 2;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_UPD   = 4'b0100,
        S_QRY   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [AW-1:0] r_node, n_node;
    logic signed [rmst_pkg::VAL_W-1:0] r_carry, n_carry;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic signed [rmst_pkg::VAL_W-1:0] r_best, n_best;
    logic r_pend, n_pend;

    logic signed [rmst_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic signed [rmst_pkg::VAL_W-1:0] r_rdata;
    logic                              w_we;
    logic [AW-1:0]                     w_waddr;
    logic [AW-1:0]                     w_raddr;
    logic signed [rmst_pkg::VAL_W-1:0] w_wdata;

    logic [CW-1:0] w_first, w_last_sat, w_leaf, w_hi0, w_hi_dec;
    logic [AW-1:0] w_parent;
    logic signed [rmst_pkg::VAL_W-1:0] w_min, w_acc;

    assign i_item.ready = (r_state == S_IDLE);

    assign w_first    = CW'(i_item.first_index);
    assign w_last_sat = (CW'(i_item.last_index) >= CW'(LEAVES)) ? CW'(LEAVES - 1)
                                                              : CW'(i_item.last_index);
    assign w_leaf     = w_first + CW'(LEAVES);
    assign w_hi0      = w_last_sat + CW'(LEAVES) + CW'(1);
    assign w_hi_dec   = r_hi - CW'(1);
    assign w_parent   = r_node >> 1;
    assign w_min      = rmst_pkg::min_s(r_carry, r_rdata);
    assign w_acc      = r_pend ? rmst_pkg::min_s(r_best, r_rdata) : r_best;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_node  = r_node;
        n_carry = r_carry;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_best  = r_best;
        n_pend  = 1'b0;
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = rmst_pkg::NEUTRAL;
        w_raddr = '0;
        o_push  = '{valid: 1'b0, value: rmst_pkg::NEUTRAL};
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_item.valid) begin
                    if (i_item.operation == rmst_pkg::OP_QUERY) begin
                        n_lo    = w_leaf;
                        n_hi    = w_hi0;
                        n_best  = rmst_pkg::NEUTRAL;
                        n_state = S_QRY;
                    end else if (w_first < CW'(LEAVES)) begin
                        // write the leaf, fetch its sibling
                        w_we    = 1'b1;
                        w_waddr = w_leaf[AW-1:0];
                        w_wdata = i_item.new_value;
                        w_raddr = w_leaf[AW-1:0] ^ AW'(1);
                        n_node  = w_leaf[AW-1:0];
                        n_carry = i_item.new_value;
                        n_state = S_UPD;
                    end
                end
            end
            S_UPD: begin
                w_we    = 1'b1;
                w_waddr = w_parent;
                w_wdata = w_min;
                n_carry = w_min;
                n_node  = w_parent;
                if (w_parent == AW'(1)) begin
                    n_state = S_IDLE;
                end else begin
                    w_raddr = w_parent ^ AW'(1);
                end
            end
            S_QRY: begin
                n_best = w_acc;
                if (r_lo < r_hi) begin
                    if (r_lo[0]) begin
                        w_raddr = r_lo[AW-1:0];
                        n_lo    = r_lo + CW'(1);
                        n_pend  = 1'b1;
                    end else if (r_hi[0]) begin
                        w_raddr = w_hi_dec[AW-1:0];
                        n_hi    = w_hi_dec;
                        n_pend  = 1'b1;
                    end else begin
                        n_lo = r_lo >> 1;
                        n_hi = r_hi >> 1;
                    end
                end else begin
                    // hold the minimum until the output stage has room
                    o_push.valid = i_free;
                    o_push.value = w_acc;
                    if (i_free) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_carry <= n_carry;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_best  <= n_best;
    end

endmodule

`default_nettype wire

// ===== src/rmst_out_stage.sv =====
// ----------------------------------------------------------------------------
// rmst_out_stage
// Output register holding one result word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rmst_pkg::t_result i_push,
    output logic                   o_free,
    rmst_out_if.source             o_result
);

    logic                              r_valid;
    logic signed [rmst_pkg::VAL_W-1:0] r_value;

    assign o_free                 = !r_valid || o_result.ready;
    assign o_result.valid         = r_valid;
    assign o_result.range_minimum = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.valid && o_free) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid && o_free) begin
            r_value <= i_push.value;
        end
    end

endmodule

`default_nettype wire

// ===== src/rmst_checker.sv =====
// ----------------------------------------------------------------------------
// rmst_checker
// Port-level checks of the range-minimum segment tree, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "range_minimum_segment_tree_defines.svh"

module rmst_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              i_in_ready,
    input wire logic                              i_in_op,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic signed [rmst_pkg::VAL_W-1:0] i_out_value
);

    // queries taken but not yet delivered
    logic [2:0] r_owed;
    logic       w_inc, w_dec;

    assign w_inc = i_in_valid && i_in_ready && (i_in_op == rmst_pkg::OP_QUERY);
    assign w_dec = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owed <= '0;
        end else if (w_inc && !w_dec) begin
            r_owed <= r_owed + 3'd1;
        end else if (w_dec && !w_inc) begin
            r_owed <= r_owed - 3'd1;
        end
    end

    `RMST_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_value), "result word changed while stalled")
    `RMST_ASSERT_IMPL(a_no_spurious, i_clk, i_rst_n, i_out_valid, r_owed != 3'd0, "result word without a query")
    `RMST_ASSERT_IMPL(a_owed_bound, i_clk, i_rst_n, 1'b1, r_owed < 3'd3, "more than two queries in flight")
    `RMST_ASSERT_IMPL(a_busy_full, i_clk, i_rst_n, r_owed == 3'd2, !i_in_ready, "request taken with both result slots held")
    `RMST_ASSERT_IMPL(a_clear_pass, i_clk, i_rst_n, $rose(i_rst_n), !i_in_ready, "request taken before clearing pass")

endmodule

bind range_minimum_segment_tree rmst_checker u_rmst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_op     (i_item.operation),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_value (o_result.range_minimum)
);

`default_nettype wire

// ===== bench/tb_range_minimum_segment_tree.sv =====
// ----------------------------------------------------------------------------
// tb_range_minimum_segment_tree
// Drives update and query words into the segment tree through valid/ready
// channels with random gaps and stalls on both sides. It keeps a flat copy of
// the positions, takes the minimum over each queried range and compares every
// returned word with the oldest outstanding minimum.
// ----------------------------------------------------------------------------
module tb_range_minimum_segment_tree;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEAVES = rmst_pkg::LEAVES_DEFAULT;

    typedef logic signed [rmst_pkg::VAL_W-1:0] t_value;
    typedef logic [rmst_pkg::IDX_W-1:0]        t_index;

    class segment_min_scoreboard;
        t_value position_value[LEAVES];
        t_value expected_minima[$];
        int     mismatches;

        function new();
            foreach (position_value[p]) position_value[p] = rmst_pkg::NEUTRAL;
            mismatches = 0;
        endfunction

        task report(string what);
            mismatches++;
            $display("%s", what);
        endtask

        function int pending();
            return expected_minima.size();
        endfunction

        // Apply an update, or work out the minimum a query must return.
        function void note_request(rmst_pkg::t_op op, t_index first, t_index last,
                                   t_value value);
            t_value best;
            best = rmst_pkg::NEUTRAL;
            if (op == rmst_pkg::OP_UPDATE) begin
                position_value[first] = value;
            end else begin
                // an empty range leaves the neutral value
                for (int p = first; p <= last; p++) begin
                    if (position_value[p] < best) best = position_value[p];
                end
                expected_minima.push_back(best);
            end
        endfunction

        task check_minimum(t_value got);
            t_value want;
            if (expected_minima.size() == 0) begin
                report($sformatf("unexpected result word: range_minimum %0d", got));
            end else begin
                want = expected_minima.pop_front();
                if (got !== want) begin
                    report($sformatf("range_minimum mismatch: expected %0d, got %0d",
                                     want, got));
                end
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    rmst_in_if  item_if ();
    rmst_out_if result_if ();

    range_minimum_segment_tree u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    segment_min_scoreboard board = new();

    bit offering       = 1'b0;
    bit sender_quiet   = 1'b0;
    bit receiver_quiet = 1'b0;
    int hold_request   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Mostly no gap, some short ones, a few long ones.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_word(rmst_pkg::t_op op, t_index first, t_index last, t_value value);
        int gap;
        gap = sender_quiet ? 0 : idle_cycles();
        if (gap > 0) begin
            if (offering) item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        // keep valid high between back-to-back words
        if (gap > 0 || !offering) item_if.valid <= 1'b1;
        offering = 1'b1;
        item_if.operation   <= op;
        item_if.first_index <= first;
        item_if.last_index  <= last;
        item_if.new_value   <= value;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        board.note_request(op, first, last, value);
    endtask

    task automatic stop_offering();
        if (offering) item_if.valid <= 1'b0;
        offering = 1'b0;
    endtask

    task automatic drain_results();
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_word();
        rmst_pkg::t_op op;
        t_index        first;
        t_index        last;
        t_value        value;
        int            r;
        op = $urandom_range(0, 1) ? rmst_pkg::OP_QUERY : rmst_pkg::OP_UPDATE;
        // favour a low window so that short ranges meet written positions
        first = ($urandom_range(0, 1) != 0) ? t_index'($urandom_range(0, 63))
                                            : t_index'($urandom_range(0, LEAVES - 1));
        r = $urandom_range(0, 99);
        if (r < 15)
            last = t_index'($urandom_range(0, LEAVES - 1));
        else if (r < 60)
            last = (first + 15 > LEAVES - 1) ? t_index'(LEAVES - 1)
                                             : t_index'(first + $urandom_range(0, 15));
        else
            last = t_index'($urandom_range(first, LEAVES - 1));
        r = $urandom_range(0, 99);
        if (r < 10)
            value = $urandom_range(0, 1) ? rmst_pkg::NEUTRAL : t_value'(32'sh8000_0000);
        else if (r < 40)
            value = t_value'($urandom_range(0, 200)) - 100;
        else
            value = $urandom;
        send_word(op, first, last, value);
    endtask

    initial begin : result_side
        int stall_left;
        int r;
        stall_left = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (result_if.valid === 1'b1 && result_if.ready === 1'b1)
                board.check_minimum(result_if.range_minimum);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                result_if.ready <= 1'b0;
            end else if (receiver_quiet) begin
                result_if.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    result_if.ready <= 1'b1;
                end else begin
                    stall_left = (r < 93) ? $urandom_range(0, 3) : $urandom_range(5, 30);
                    result_if.ready <= 1'b0;
                end
            end
        end
    end

    initial begin : stimulus
        i_rst_n                 <= 1'b0;
        item_if.valid           <= 1'b0;
        item_if.operation       <= rmst_pkg::OP_UPDATE;
        item_if.first_index     <= '0;
        item_if.last_index      <= '0;
        item_if.new_value       <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // untouched tree, empty range, extremes and alternating bit patterns
        send_word(rmst_pkg::OP_QUERY,  10'd0,    10'd1023, 32'sd0);
        send_word(rmst_pkg::OP_QUERY,  10'd1023, 10'd0,    32'sd0);
        send_word(rmst_pkg::OP_UPDATE, 10'd0,    10'd1023, 32'sh8000_0000);
        send_word(rmst_pkg::OP_UPDATE, 10'd1023, 10'd0,    -32'sd5);
        send_word(rmst_pkg::OP_UPDATE, 10'd512,  10'd0,    32'sd0);
        send_word(rmst_pkg::OP_UPDATE, 10'd511,  10'd0,    32'sh5555_5555);
        send_word(rmst_pkg::OP_UPDATE, 10'd3,    10'd0,    32'shAAAA_AAAA);
        send_word(rmst_pkg::OP_QUERY,  10'd0,    10'd0,    32'sh7FFF_FFFF);
        send_word(rmst_pkg::OP_QUERY,  10'd1,    10'd1023, 32'sd0);
        send_word(rmst_pkg::OP_QUERY,  10'd1023, 10'd1023, 32'sd0);
        send_word(rmst_pkg::OP_QUERY,  10'd4,    10'd1022, 32'sd0);
        send_word(rmst_pkg::OP_QUERY,  10'd5,    10'd5,    32'sd0);
        send_word(rmst_pkg::OP_UPDATE, 10'd0,    10'd0,    rmst_pkg::NEUTRAL);
        send_word(rmst_pkg::OP_QUERY,  10'd0,    10'd2,    32'sd0);
        send_word(rmst_pkg::OP_QUERY,  10'd512,  10'd511,  32'sd0);
        send_word(rmst_pkg::OP_UPDATE, 10'd1023, 10'd0,    rmst_pkg::NEUTRAL);
        send_word(rmst_pkg::OP_QUERY,  10'd1000, 10'd1023, 32'sd0);
        send_word(rmst_pkg::OP_QUERY,  10'd0,    10'd1023, 32'sd0);

        // hold the sender until every outstanding word has come back
        stop_offering();
        drain_results();

        repeat (300) send_random_word();

        // stall the receiver for a long stretch while words keep coming
        hold_request = 400;
        sender_quiet = 1'b1;
        repeat (30) send_random_word();

        // a stretch with no idling on either side
        receiver_quiet = 1'b1;
        repeat (150) send_random_word();
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;

        repeat (350) send_random_word();

        stop_offering();
        drain_results();
        repeat (40) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
